>>> rtl/bounded_event_queue_coalesce_evict_defines.svh
// assertion macros shared by the queue checker
// no dependencies; clk and arst_n must exist in the using scope
`ifndef BOUNDED_EVENT_QUEUE_COALESCE_EVICT_DEFINES_SVH
`define BOUNDED_EVENT_QUEUE_COALESCE_EVICT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BEQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define BEQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/beq_pkg.sv
// types and codes of the bounded event queue
// used by the top level, its checker and the testbench
package beq_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CO_RD,
		ST_CO_CHK,
		ST_TAIL,
		ST_EV_RD,
		ST_EV_CHK,
		ST_HD_RD,
		ST_HD_CHK,
		ST_DQ_RD,
		ST_DQ_CHK,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		STAT_QUEUED    = 3'd0,
		STAT_COALESCED = 3'd1,
		STAT_DROPPED   = 3'd2,
		STAT_POPPED    = 3'd3,
		STAT_EMPTY     = 3'd4,
		STAT_FLUSHED   = 3'd5,
		STAT_NOT_ACC   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FN_ENQ     = 2'd0,
		FN_DEQ     = 2'd1,
		FN_FLUSH   = 2'd2,
		FN_RESTART = 2'd3
	} func_t;

	localparam logic [2:0] REG_LOSSY_MASK = 3'd0;
	localparam logic [2:0] REG_COAL_MASK  = 3'd1;
	localparam logic [2:0] REG_MAX_ITEM   = 3'd2;
	localparam logic [2:0] REG_MAX_BYTES  = 3'd3;
	localparam logic [2:0] REG_MAX_ENT    = 3'd4;

	localparam logic [23:0] MAX_ITEM_RST  = 24'd262144;
	localparam logic [23:0] MAX_BYTES_RST = 24'd4194304;
	localparam logic [10:0] MAX_ENT_RST   = 11'd1024;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

endpackage

>>> rtl/beq_mem.sv
// entry store of the event queue: one write port, one registered read port
// no package dependencies
module beq_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = 10,
	parameter int DW = 62
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bounded_event_queue_coalesce_evict.sv
// Bounded event queue with coalescing and eviction. Entries live in one circular
// memory with a registered read; every memory access goes through a read state and
// a check state. A coalescible enqueue walks back from the newest entry. When the
// newcomer does not fit, one compaction pass walks the queue, then head evictions
// follow. One transaction is worked at a time; a new one is taken while the
// previous result still waits at the output.
module bounded_event_queue_coalesce_evict #(
	parameter int QUEUE_DEPTH = 1024,
	parameter int TYPE_COUNT = 64,
	parameter int TAG_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic [5:0]          evt_type,
	input  logic [23:0]         byte_cost,
	input  logic [TAG_BITS-1:0] payload_tag,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [10:0]         evicted_count,
	output logic [5:0]          out_type,
	output logic [TAG_BITS-1:0] out_tag,
	output logic [23:0]         out_bytes,
	output logic [10:0]         occupancy,
	output logic [23:0]         queued_byte_total,
	output logic [31:0]         dropped_total,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [63:0]         cfg_wdata
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > 11) ? CW : 11;
	localparam int DW = 30 + TAG_BITS;

	beq_pkg::state_t state_q, state_d;

	logic [63:0] lossy_q, coal_q;
	logic [23:0] max_item_q, max_bytes_q;
	logic [10:0] max_ent_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q, k_q, r_q, w_q, n_q, ev_q;
	logic [23:0] sum_q;
	logic [31:0] drop_q;
	logic acc_q, passed_q;

	logic [5:0] type_q;
	logic [23:0] cost_q;
	logic [TAG_BITS-1:0] tag_q;
	beq_pkg::status_t res_q;
	logic [5:0] po_type_q;
	logic [23:0] po_bytes_q;
	logic [TAG_BITS-1:0] po_tag_q;

	logic out_valid_q;
	logic [2:0] out_status_q;
	logic [10:0] out_ev_q, out_occ_q;
	logic [5:0] out_type_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic [23:0] out_bytes_q, out_sum_q;
	logic [31:0] out_drop_q;

	logic re, we;
	logic [AW-1:0] raddr, waddr;
	logic [DW-1:0] rdata, wdata;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(QUEUE_DEPTH)) begin
			s = s - (CW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic type_bit(input logic [63:0] mask, input logic [5:0] t);
		return ({1'b0, t} < 7'(TYPE_COUNT)) && mask[t];
	endfunction

	logic [5:0] d_type;
	logic [23:0] d_bytes;
	logic [TAG_BITS-1:0] d_tag;
	logic [LW-1:0] lim;
	logic fits, lossy_new, d_lossy, match, co_ok, ev_remove, out_free, last_r;
	logic [23:0] without;
	logic [DW-1:0] new_word;

	assign d_type = rdata[DW-1 -: 6];
	assign d_bytes = rdata[TAG_BITS +: 24];
	assign d_tag = rdata[TAG_BITS-1:0];
	assign new_word = {type_q, cost_q, tag_q};

	assign lim = (LW'(max_ent_q) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : LW'(max_ent_q);
	assign fits = (LW'(cnt_q) < lim) && (sum_q <= max_bytes_q) && (cost_q <= max_bytes_q - sum_q);
	assign lossy_new = type_bit(lossy_q, type_q);
	assign d_lossy = type_bit(lossy_q, d_type);
	assign match = (d_type == type_q);
	assign without = sum_q - d_bytes;
	assign co_ok = (without <= max_bytes_q) && (cost_q <= max_bytes_q - without);
	assign ev_remove = !fits && d_lossy;
	assign last_r = (r_q == n_q - 1'b1);
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			beq_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						beq_pkg::FN_ENQ: begin
							if (!acc_q || byte_cost > max_item_q) begin
								state_d = beq_pkg::ST_DONE;
							end else if (type_bit(coal_q, evt_type) && cnt_q != '0) begin
								state_d = beq_pkg::ST_CO_RD;
							end else begin
								state_d = beq_pkg::ST_TAIL;
							end
						end
						beq_pkg::FN_DEQ: begin
							state_d = (cnt_q == '0) ? beq_pkg::ST_DONE : beq_pkg::ST_DQ_RD;
						end
						default: state_d = beq_pkg::ST_DONE;
					endcase
				end
			end
			beq_pkg::ST_CO_RD: state_d = beq_pkg::ST_CO_CHK;
			beq_pkg::ST_CO_CHK: begin
				if (match) begin
					state_d = co_ok ? beq_pkg::ST_DONE : beq_pkg::ST_TAIL;
				end else begin
					state_d = (k_q == '0) ? beq_pkg::ST_TAIL : beq_pkg::ST_CO_RD;
				end
			end
			beq_pkg::ST_TAIL: begin
				priority if (fits) begin
					state_d = beq_pkg::ST_DONE;
				end else if (cnt_q != '0 && !passed_q) begin
					state_d = beq_pkg::ST_EV_RD;
				end else if (cnt_q != '0 && !lossy_new) begin
					state_d = beq_pkg::ST_HD_RD;
				end else begin
					state_d = beq_pkg::ST_DONE;
				end
			end
			beq_pkg::ST_EV_RD: state_d = beq_pkg::ST_EV_CHK;
			beq_pkg::ST_EV_CHK: state_d = last_r ? beq_pkg::ST_TAIL : beq_pkg::ST_EV_RD;
			beq_pkg::ST_HD_RD: state_d = beq_pkg::ST_HD_CHK;
			beq_pkg::ST_HD_CHK: state_d = beq_pkg::ST_TAIL;
			beq_pkg::ST_DQ_RD: state_d = beq_pkg::ST_DQ_CHK;
			beq_pkg::ST_DQ_CHK: state_d = beq_pkg::ST_DONE;
			beq_pkg::ST_DONE: state_d = out_free ? beq_pkg::ST_IDLE : beq_pkg::ST_DONE;
			default: state_d = beq_pkg::ST_IDLE;
		endcase
	end

	// memory control and handshake
	always_comb begin
		in_ready = (state_q == beq_pkg::ST_IDLE);
		re = 1'b0;
		raddr = head_q;
		we = 1'b0;
		waddr = head_q;
		wdata = new_word;
		unique case (state_q)
			beq_pkg::ST_CO_RD: begin
				re = 1'b1;
				raddr = phys(head_q, k_q);
			end
			beq_pkg::ST_EV_RD: begin
				re = 1'b1;
				raddr = phys(head_q, r_q);
			end
			beq_pkg::ST_HD_RD, beq_pkg::ST_DQ_RD: re = 1'b1;
			beq_pkg::ST_CO_CHK: begin
				we = match && co_ok;
				waddr = phys(head_q, k_q);
			end
			beq_pkg::ST_EV_CHK: begin
				// compaction: survivors slide down over removed entries
				we = !ev_remove && (w_q != r_q);
				waddr = phys(head_q, w_q);
				wdata = rdata;
			end
			beq_pkg::ST_TAIL: begin
				we = fits;
				waddr = phys(head_q, cnt_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= beq_pkg::ST_IDLE;
			lossy_q <= '0;
			coal_q <= '0;
			max_item_q <= beq_pkg::MAX_ITEM_RST;
			max_bytes_q <= beq_pkg::MAX_BYTES_RST;
			max_ent_q <= beq_pkg::MAX_ENT_RST;
			head_q <= '0;
			cnt_q <= '0;
			k_q <= '0;
			r_q <= '0;
			w_q <= '0;
			n_q <= '0;
			ev_q <= '0;
			sum_q <= '0;
			drop_q <= '0;
			acc_q <= 1'b1;
			passed_q <= 1'b0;
			type_q <= '0;
			cost_q <= '0;
			tag_q <= '0;
			res_q <= beq_pkg::STAT_QUEUED;
			po_type_q <= '0;
			po_bytes_q <= '0;
			po_tag_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= '0;
			out_ev_q <= '0;
			out_occ_q <= '0;
			out_type_q <= '0;
			out_tag_q <= '0;
			out_bytes_q <= '0;
			out_sum_q <= '0;
			out_drop_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					beq_pkg::REG_LOSSY_MASK: lossy_q <= cfg_wdata;
					beq_pkg::REG_COAL_MASK: coal_q <= cfg_wdata;
					beq_pkg::REG_MAX_ITEM: max_item_q <= cfg_wdata[23:0];
					beq_pkg::REG_MAX_BYTES: max_bytes_q <= cfg_wdata[23:0];
					beq_pkg::REG_MAX_ENT: max_ent_q <= cfg_wdata[10:0];
					default: ;
				endcase
			end
			if (state_q == beq_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				beq_pkg::ST_IDLE: begin
					if (in_valid) begin
						type_q <= evt_type;
						cost_q <= byte_cost;
						tag_q <= payload_tag;
						ev_q <= '0;
						passed_q <= 1'b0;
						po_type_q <= '0;
						po_bytes_q <= '0;
						po_tag_q <= '0;
						k_q <= cnt_q - 1'b1;
						unique case (func)
							beq_pkg::FN_ENQ: begin
								if (!acc_q) begin
									res_q <= beq_pkg::STAT_NOT_ACC;
								end else if (byte_cost > max_item_q) begin
									res_q <= beq_pkg::STAT_DROPPED;
									drop_q <= beq_pkg::sat_add(drop_q, 32'd1);
								end
							end
							beq_pkg::FN_DEQ: res_q <= beq_pkg::STAT_EMPTY;
							beq_pkg::FN_FLUSH: begin
								acc_q <= 1'b0;
								drop_q <= beq_pkg::sat_add(drop_q, 32'(cnt_q));
								cnt_q <= '0;
								sum_q <= '0;
								res_q <= beq_pkg::STAT_FLUSHED;
							end
							default: begin
								acc_q <= 1'b1;
								drop_q <= '0;
								cnt_q <= '0;
								sum_q <= '0;
								res_q <= beq_pkg::STAT_FLUSHED;
							end
						endcase
					end
				end
				beq_pkg::ST_CO_CHK: begin
					if (match) begin
						if (co_ok) begin
							sum_q <= without + cost_q;
							res_q <= beq_pkg::STAT_COALESCED;
						end
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				beq_pkg::ST_TAIL: begin
					priority if (fits) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_q + cost_q;
						res_q <= beq_pkg::STAT_QUEUED;
					end else if (cnt_q != '0 && !passed_q) begin
						r_q <= '0;
						w_q <= '0;
						n_q <= cnt_q;
						passed_q <= 1'b1;
					end else if (cnt_q != '0 && !lossy_new) begin
						// head eviction follows
					end else begin
						drop_q <= beq_pkg::sat_add(drop_q, 32'd1);
						res_q <= beq_pkg::STAT_DROPPED;
					end
				end
				beq_pkg::ST_EV_CHK: begin
					if (ev_remove) begin
						sum_q <= sum_q - d_bytes;
						cnt_q <= cnt_q - 1'b1;
						drop_q <= beq_pkg::sat_add(drop_q, 32'd1);
						ev_q <= ev_q + 1'b1;
					end else begin
						w_q <= w_q + 1'b1;
					end
					r_q <= r_q + 1'b1;
				end
				beq_pkg::ST_HD_CHK: begin
					sum_q <= sum_q - d_bytes;
					cnt_q <= cnt_q - 1'b1;
					head_q <= phys(head_q, CW'(1));
					drop_q <= beq_pkg::sat_add(drop_q, 32'd1);
					ev_q <= ev_q + 1'b1;
				end
				beq_pkg::ST_DQ_CHK: begin
					po_type_q <= d_type;
					po_bytes_q <= d_bytes;
					po_tag_q <= d_tag;
					sum_q <= sum_q - d_bytes;
					cnt_q <= cnt_q - 1'b1;
					head_q <= phys(head_q, CW'(1));
					res_q <= beq_pkg::STAT_POPPED;
				end
				beq_pkg::ST_DONE: begin
					if (out_free) begin
						out_status_q <= res_q;
						out_ev_q <= 11'(ev_q);
						out_type_q <= po_type_q;
						out_tag_q <= po_tag_q;
						out_bytes_q <= po_bytes_q;
						out_occ_q <= 11'(cnt_q);
						out_sum_q <= sum_q;
						out_drop_q <= drop_q;
					end
				end
				default: ;
			endcase
		end
	end

	beq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.AW(AW),
		.DW(DW)
	) u_mem (
		.clk(clk),
		.re(re),
		.raddr(raddr),
		.rdata(rdata),
		.we(we),
		.waddr(waddr),
		.wdata(wdata)
	);

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign evicted_count = out_ev_q;
	assign out_type = out_type_q;
	assign out_tag = out_tag_q;
	assign out_bytes = out_bytes_q;
	assign occupancy = out_occ_q;
	assign queued_byte_total = out_sum_q;
	assign dropped_total = out_drop_q;

endmodule

>>> rtl/beq_checker.sv
// port-level checks of the bounded event queue, bound to the top level
// depends on beq_pkg and bounded_event_queue_coalesce_evict_defines.svh
`include "bounded_event_queue_coalesce_evict_defines.svh"

module beq_checker #(
	parameter int TAG_BITS = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [2:0]          status,
	input logic [10:0]         evicted_count,
	input logic [5:0]          out_type,
	input logic [TAG_BITS-1:0] out_tag,
	input logic [23:0]         out_bytes,
	input logic [23:0]         queued_byte_total,
	input logic [10:0]         occupancy
);

	`BEQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result transaction dropped while stalled")

	// only a popped result carries entry data
	`BEQ_ASSERT_IMP(a_pop_fields, out_valid && status != beq_pkg::STAT_POPPED, out_type == '0 && out_tag == '0 && out_bytes == '0, "entry fields set without pop")

	`BEQ_ASSERT_IMP(a_evict_enq, out_valid && (status == beq_pkg::STAT_POPPED || status == beq_pkg::STAT_EMPTY || status == beq_pkg::STAT_FLUSHED || status == beq_pkg::STAT_NOT_ACC), evicted_count == '0, "evictions reported outside enqueue")

	`BEQ_ASSERT_IMP(a_empty_state, out_valid && (status == beq_pkg::STAT_EMPTY || status == beq_pkg::STAT_FLUSHED), occupancy == '0 && queued_byte_total == '0, "queue not empty after flush or empty pop")

endmodule

bind bounded_event_queue_coalesce_evict beq_checker #(.TAG_BITS(TAG_BITS)) u_beq_checker (.*);

>>> verif/bounded_event_queue_coalesce_evict_test.sv
// self-checking testbench of the bounded event queue with coalescing and eviction
// depends on beq_pkg and the bounded_event_queue_coalesce_evict top level; holds its own
// model of the queue and compares every result transaction field by field
module bounded_event_queue_coalesce_evict_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 1024;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct {
		logic [5:0]  etype;
		logic [23:0] cost;
		logic [31:0] tag;
	} slot_t;

	typedef struct {
		beq_pkg::status_t st;
		logic [10:0] evicted;
		logic [5:0]  otype;
		logic [31:0] otag;
		logic [23:0] obytes;
		logic [10:0] occ;
		logic [23:0] qbytes;
		logic [31:0] drops;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [5:0]  evt_type;
	logic [23:0] byte_cost;
	logic [31:0] payload_tag;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [10:0] evicted_count;
	logic [5:0]  out_type;
	logic [31:0] out_tag;
	logic [23:0] out_bytes;
	logic [10:0] occupancy;
	logic [23:0] queued_byte_total;
	logic [31:0] dropped_total;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [63:0] cfg_wdata;

	// model state
	slot_t       held[$];
	int unsigned held_bytes;
	logic [31:0] drop_cnt;
	bit          accepting;
	logic [63:0] lossy_mask;
	logic [63:0] coal_mask;
	logic [23:0] item_max;
	logic [23:0] budget;
	logic [10:0] entry_max;

	outcome_t pending[$];
	int  errors;
	bit  idle_on;
	int  long_hold_req;
	longint cycles;

	bounded_event_queue_coalesce_evict dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic int unsigned entry_cap();
		return (entry_max > DEPTH) ? DEPTH : entry_max;
	endfunction

	function automatic bit room_for(int unsigned c);
		if (held.size() >= entry_cap())
			return 0;
		if (held_bytes > budget)
			return 0;
		return c <= budget - held_bytes;
	endfunction

	function automatic void add_drops(int unsigned n);
		longint s;
		s = longint'(drop_cnt) + n;
		drop_cnt = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic beq_pkg::status_t enqueue_event(logic [5:0] t, logic [23:0] c,
			logic [31:0] g, ref int unsigned ev);
		int victim;
		int unsigned without;
		slot_t s;
		if (!accepting)
			return beq_pkg::STAT_NOT_ACC;
		if (c > item_max) begin
			add_drops(1);
			return beq_pkg::STAT_DROPPED;
		end
		if (coal_mask[t]) begin
			for (int k = held.size() - 1; k >= 0; k--) begin
				if (held[k].etype == t) begin
					without = held_bytes - held[k].cost;
					if (without <= budget && c <= budget - without) begin
						held_bytes = without + c;
						held[k].cost = c;
						held[k].tag = g;
						return beq_pkg::STAT_COALESCED;
					end
					break;
				end
			end
		end
		while (!room_for(c) && held.size() > 0) begin
			victim = -1;
			foreach (held[i]) begin
				if (lossy_mask[held[i].etype]) begin
					victim = i;
					break;
				end
			end
			if (victim < 0) begin
				// nothing lossy left: a lossy newcomer loses, a lossless one takes the head
				if (lossy_mask[t]) begin
					add_drops(1);
					return beq_pkg::STAT_DROPPED;
				end
				victim = 0;
			end
			held_bytes -= held[victim].cost;
			held.delete(victim);
			add_drops(1);
			ev++;
		end
		if (!room_for(c)) begin
			add_drops(1);
			return beq_pkg::STAT_DROPPED;
		end
		s.etype = t;
		s.cost = c;
		s.tag = g;
		held.insert(held.size(), s);
		held_bytes += c;
		return beq_pkg::STAT_QUEUED;
	endfunction

	function automatic void predict_outcome(beq_pkg::func_t f, logic [5:0] t, logic [23:0] c,
			logic [31:0] g);
		outcome_t o;
		int unsigned ev;
		ev = 0;
		o.otype = '0;
		o.otag = '0;
		o.obytes = '0;
		case (f)
			beq_pkg::FN_ENQ: begin
				o.st = enqueue_event(t, c, g, ev);
			end
			beq_pkg::FN_DEQ: begin
				if (held.size() == 0) begin
					o.st = beq_pkg::STAT_EMPTY;
				end else begin
					o.st = beq_pkg::STAT_POPPED;
					o.otype = held[0].etype;
					o.otag = held[0].tag;
					o.obytes = held[0].cost;
					held_bytes -= held[0].cost;
					held.delete(0);
				end
			end
			beq_pkg::FN_FLUSH: begin
				accepting = 0;
				add_drops(held.size());
				held.delete();
				held_bytes = 0;
				o.st = beq_pkg::STAT_FLUSHED;
			end
			default: begin
				held.delete();
				held_bytes = 0;
				drop_cnt = '0;
				accepting = 1;
				o.st = beq_pkg::STAT_FLUSHED;
			end
		endcase
		o.evicted = 11'(ev);
		o.occ = 11'(held.size());
		o.qbytes = 24'(held_bytes);
		o.drops = drop_cnt;
		pending.insert(pending.size(), o);
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// result side: random stalls, the long hold, and the compare
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending.size() == 0) begin
					$error("result transaction with nothing expected, status %0d", status);
					errors++;
				end else begin
					outcome_t o;
					o = pending[0];
					pending.delete(0);
					check_field("status", o.st, status);
					check_field("evicted_count", o.evicted, evicted_count);
					check_field("out_type", o.otype, out_type);
					check_field("out_tag", o.otag, out_tag);
					check_field("out_bytes", o.obytes, out_bytes);
					check_field("occupancy", o.occ, occupancy);
					check_field("queued_byte_total", o.qbytes, queued_byte_total);
					check_field("dropped_total", o.drops, dropped_total);
				end
			end
			if (long_hold_req > 0) begin
				stall_left = long_hold_req;
				long_hold_req = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// valid stays high across back-to-back transactions; it only drops for a gap
	task automatic send_op(beq_pkg::func_t f, logic [5:0] t, logic [23:0] c, logic [31:0] g);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		evt_type <= t;
		byte_cost <= c;
		payload_tag <= g;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_outcome(f, t, c, g);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			beq_pkg::REG_LOSSY_MASK: lossy_mask = v;
			beq_pkg::REG_COAL_MASK:  coal_mask = v;
			beq_pkg::REG_MAX_ITEM:   item_max = v[23:0];
			beq_pkg::REG_MAX_BYTES:  budget = v[23:0];
			beq_pkg::REG_MAX_ENT:    entry_max = v[10:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [63:0] lm, logic [63:0] cm, logic [23:0] it,
			logic [23:0] qb, logic [10:0] ne);
		drain();
		write_reg(beq_pkg::REG_LOSSY_MASK, lm);
		write_reg(beq_pkg::REG_COAL_MASK, cm);
		write_reg(beq_pkg::REG_MAX_ITEM, {40'd0, it});
		write_reg(beq_pkg::REG_MAX_BYTES, {40'd0, qb});
		write_reg(beq_pkg::REG_MAX_ENT, {53'd0, ne});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		// reset values first
		send_op(beq_pkg::FN_DEQ, 6'd0, 24'd0, 32'd0);
		send_op(beq_pkg::FN_ENQ, 6'd63, 24'hFFFFFF, 32'hFFFF_FFFF);
		send_op(beq_pkg::FN_ENQ, 6'd0, 24'd0, 32'd0);
		send_op(beq_pkg::FN_ENQ, 6'd63, beq_pkg::MAX_ITEM_RST, 32'hFFFF_FFFF);
		send_op(beq_pkg::FN_DEQ, 6'd0, 24'd0, 32'd0);
		send_op(beq_pkg::FN_FLUSH, 6'd0, 24'd0, 32'd0);
		send_op(beq_pkg::FN_ENQ, 6'd1, 24'd5, 32'h1234);
		send_op(beq_pkg::FN_DEQ, 6'd0, 24'd0, 32'd0);
		send_op(beq_pkg::FN_RESTART, 6'd0, 24'd0, 32'd0);
		// coalescing on type 5, type 7 lossy, tight budget of four entries
		set_config(64'h80, 64'h20, 24'd60, 24'd100, 11'd4);
		send_op(beq_pkg::FN_ENQ, 6'd5, 24'd10, 32'hA);
		send_op(beq_pkg::FN_ENQ, 6'd5, 24'd20, 32'hB);
		send_op(beq_pkg::FN_ENQ, 6'd7, 24'd30, 32'hC);
		send_op(beq_pkg::FN_ENQ, 6'd7, 24'd30, 32'hD);
		send_op(beq_pkg::FN_ENQ, 6'd2, 24'd50, 32'hE);
		send_op(beq_pkg::FN_ENQ, 6'd3, 24'd40, 32'hF);
		send_op(beq_pkg::FN_ENQ, 6'd7, 24'd60, 32'h10);
		send_op(beq_pkg::FN_ENQ, 6'd4, 24'd60, 32'h11);
		send_op(beq_pkg::FN_ENQ, 6'd5, 24'd60, 32'h12);
		// budget lowered below what is queued: the coalesce still fits once the old entry's bytes are taken out
		set_config(64'h80, 64'h20, 24'd60, 24'd30, 11'd4);
		send_op(beq_pkg::FN_ENQ, 6'd5, 24'd5, 32'h13);
		// unknown register indexes must leave everything alone
		drain();
		write_reg(3'd5, {$urandom, $urandom});
		write_reg(3'd6, {$urandom, $urandom});
		write_reg(3'd7, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
		send_op(beq_pkg::FN_ENQ, 6'd9, 24'd1, 32'h14);
		// entry limit zero, then above the depth
		set_config(64'h0, 64'h0, 24'd60, 24'd100, 11'd0);
		send_op(beq_pkg::FN_ENQ, 6'd9, 24'd1, 32'h15);
		send_op(beq_pkg::FN_DEQ, 6'd0, 24'd0, 32'd0);
		set_config('1, '1, 24'hFFFFFF, 24'hFFFFFF, 11'h7FF);
		send_op(beq_pkg::FN_ENQ, 6'd63, 24'hFFFFFF, 32'h5555_AAAA);
		send_op(beq_pkg::FN_ENQ, 6'd62, 24'd1, 32'hAAAA_5555);
	endtask

	task automatic random_burst(int n, logic [23:0] it);
		logic [5:0] t;
		logic [23:0] c;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 7) == 0)
				t = 6'($urandom_range(0, 63));
			else
				t = 6'($urandom_range(0, 7));
			if ($urandom_range(0, 15) == 0)
				c = 24'($urandom);
			else
				c = 24'($urandom_range(0, it + it / 8 + 1));
			if (r < 62)
				send_op(beq_pkg::FN_ENQ, t, c, $urandom);
			else if (r < 92)
				send_op(beq_pkg::FN_DEQ, t, c, $urandom);
			else if (r < 95)
				send_op(beq_pkg::FN_FLUSH, t, c, $urandom);
			else
				send_op(beq_pkg::FN_RESTART, t, c, $urandom);
		end
	endtask

	task automatic test_random();
		logic [63:0] lm;
		logic [63:0] cm;
		logic [23:0] it;
		logic [23:0] qb;
		logic [10:0] ne;
		for (int ph = 0; ph < 8; ph++) begin
			lm = {$urandom, $urandom};
			cm = {$urandom, $urandom};
			it = 24'($urandom_range(1, 400));
			qb = 24'($urandom_range(0, 1500));
			ne = 11'($urandom_range(1, 24));
			case (ph)
				0: begin lm = '0; cm = '1; end
				1: begin lm = '1; cm = '0; end
				2: begin it = 24'd0; end
				3: begin it = 24'hFFFFFF; qb = 24'hFFFFFF; ne = 11'd1024; end
				4: begin qb = 24'd0; end
				5: begin ne = 11'd1; end
				default: ;
			endcase
			set_config(lm, cm, it, qb, ne);
			send_op(beq_pkg::FN_RESTART, 6'd0, 24'd0, 32'd0);
			random_burst(60, (it > 400) ? 24'd400 : it);
		end
	endtask

	task automatic test_backpressure();
		set_config({$urandom, $urandom}, {$urandom, $urandom}, 24'd200, 24'd900, 11'd16);
		long_hold_req = 400;
		random_burst(30, 24'd200);
	endtask

	task automatic test_steady();
		idle_on = 0;
		set_config({$urandom, $urandom}, {$urandom, $urandom}, 24'd300, 24'd1200, 11'd12);
		random_burst(50, 24'd300);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= beq_pkg::FN_ENQ;
		evt_type <= '0;
		byte_cost <= '0;
		payload_tag <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		errors = 0;
		idle_on = 1;
		long_hold_req = 0;
		held.delete();
		held_bytes = 0;
		drop_cnt = '0;
		accepting = 1;
		lossy_mask = '0;
		coal_mask = '0;
		item_max = beq_pkg::MAX_ITEM_RST;
		budget = beq_pkg::MAX_BYTES_RST;
		entry_max = beq_pkg::MAX_ENT_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_steady();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (pending.size() != 0)
				$error("%0d expected results never arrived", pending.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
